// ----- rtl/bbps_pkg.sv -----
// ----------------------------------------------------------------------------
// bbps_pkg
// Shared types and codes of the boost/buck PWM supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package bbps_pkg;

    localparam int DUTY_W   = 17;
    localparam int REQ_W    = 18;
    localparam int OP_W     = 3;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 4;
    localparam int CFG_AW   = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 5;
    localparam int OUT_TDATA_W = 80;

    localparam logic [OP_W-1:0] OP_MANUAL_SET  = 3'd0;
    localparam logic [OP_W-1:0] OP_CONTROL_SET = 3'd1;
    localparam logic [OP_W-1:0] OP_ENABLE      = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE_BOTH = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE     = 3'd4;

    localparam logic [SEL_W-1:0] SEL_BOOST   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_BUCK    = 2'd1;
    localparam logic [SEL_W-1:0] SEL_ALL     = 2'd2;
    localparam logic [SEL_W-1:0] SEL_UNKNOWN = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_HARDWARE_READY     = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_COMPLEMENTARY_MODE = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ALLOW_DUAL_STAGE   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MANUAL_MAX_DUTY    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_BOOST_CONTROL_MAX  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_BUCK_CONTROL_MAX   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_MIN_ENABLED_DUTY   = 3'd6;

    localparam logic [DUTY_W-1:0] RST_MANUAL_MAX   = 17'd30000;
    localparam logic [DUTY_W-1:0] RST_BOOST_CTRL   = 17'd30000;
    localparam logic [DUTY_W-1:0] RST_BUCK_CTRL    = 17'd85000;
    localparam logic [DUTY_W-1:0] RST_MIN_ENABLED  = 17'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED      = 4'd0,
        ST_STAGED       = 4'd1,
        ST_ZERO_DIS     = 4'd2,
        ST_NOT_READY    = 4'd3,
        ST_RANGE        = 4'd4,
        ST_STAGE        = 4'd5,
        ST_FAULT_HELD   = 4'd6,
        ST_INTERLOCK    = 4'd7,
        ST_ZERO_REFUSED = 4'd8
    } status_t;

    typedef struct packed {
        logic              hardware_ready;
        logic              complementary_mode;
        logic              allow_dual_stage;
        logic [DUTY_W-1:0] manual_max_duty;
        logic [DUTY_W-1:0] boost_control_max;
        logic [DUTY_W-1:0] buck_control_max;
        logic [DUTY_W-1:0] min_enabled_duty;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] boost_duty;
        logic [DUTY_W-1:0] buck_duty;
        logic              boost_en;
        logic              buck_en;
        logic              fault;
        logic [DUTY_W-1:0] boost_a;
        logic [DUTY_W-1:0] boost_b;
        logic [DUTY_W-1:0] buck_a;
        logic [DUTY_W-1:0] buck_b;
    } sup_state_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SEL_W-1:0] stage_select;
        logic [REQ_W-1:0] duty_request;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/bbps_core.sv -----
// ----------------------------------------------------------------------------
// bbps_core
// Next-state and status decode for one supervisor command.
// ----------------------------------------------------------------------------
`default_nettype none

module bbps_core #(
    parameter int DUTY_FULL_SCALE = 100000
) (
    input  bbps_pkg::cfg_t       cfg,
    input  bbps_pkg::cmd_t       cmd,
    input  bbps_pkg::sup_state_t cur,
    output bbps_pkg::sup_state_t nxt,
    output logic                 accepted,
    output bbps_pkg::status_t    status
);
    import bbps_pkg::*;

    localparam int FS_BITS = $clog2(DUTY_FULL_SCALE + 1);
    localparam int CW      = (FS_BITS > DUTY_W) ? FS_BITS : DUTY_W;
    localparam logic [CW-1:0] FULL = CW'(DUTY_FULL_SCALE);

    function automatic sup_state_t stage_off(sup_state_t s, logic st);
        sup_state_t r;
        r = s;
        if (!st)
        begin
            r.boost_a  = '0;
            r.boost_b  = '0;
            r.boost_en = 1'b0;
        end
        else
        begin
            r.buck_a  = '0;
            r.buck_b  = '0;
            r.buck_en = 1'b0;
        end
        return r;
    endfunction

    function automatic sup_state_t drive(sup_state_t s, logic st, logic [DUTY_W-1:0] d,
                                         logic comp);
        sup_state_t    r;
        logic [CW-1:0] dx;
        logic [CW-1:0] diff;
        r    = s;
        dx   = CW'(d);
        diff = FULL - dx;
        if (!st)
        begin
            if (comp)
            begin
                r.boost_a = (dx > FULL) ? '0 : diff[DUTY_W-1:0];
            end
            else
            begin
                r.boost_a = '0;
                r.boost_b = d;
            end
        end
        else
        begin
            r.buck_a = d;
            if (!comp)
            begin
                r.buck_b = '0;
            end
        end
        return r;
    endfunction

    logic              neg;
    logic [DUTY_W-1:0] d;
    logic [DUTY_W-1:0] limit;
    logic              st;
    logic              other_en;
    logic              self_en;
    logic              ok0;
    logic              ok1;
    logic              oks;
    sup_state_t        s;

    assign neg = cmd.duty_request[REQ_W-1];
    assign d   = cmd.duty_request[DUTY_W-1:0];
    assign st  = cmd.stage_select[0];

    always_comb
    begin
        limit = cfg.manual_max_duty;
        if (cmd.operation == OP_CONTROL_SET)
        begin
            limit = (cmd.stage_select == SEL_BUCK) ? cfg.buck_control_max
                                                   : cfg.boost_control_max;
        end
    end

    assign self_en  = st ? cur.buck_en : cur.boost_en;
    assign other_en = st ? cur.boost_en : cur.buck_en;
    assign ok0      = cur.boost_duty > cfg.min_enabled_duty;
    assign ok1      = cur.buck_duty > cfg.min_enabled_duty;
    assign oks      = st ? ok1 : ok0;

    always_comb
    begin
        s        = cur;
        accepted = 1'b0;
        status   = ST_STAGE;
        case (cmd.operation)
            OP_MANUAL_SET, OP_CONTROL_SET:
            begin
                if (!cfg.hardware_ready)
                begin
                    s.fault = 1'b1;
                    status  = ST_NOT_READY;
                end
                else if (neg || d > limit)
                begin
                    s       = stage_off(stage_off(s, 1'b0), 1'b1);
                    s.fault = 1'b1;
                    status  = ST_RANGE;
                end
                else if (cmd.stage_select == SEL_ALL || cmd.stage_select == SEL_UNKNOWN)
                begin
                    s       = stage_off(stage_off(s, 1'b0), 1'b1);
                    s.fault = 1'b1;
                    status  = ST_STAGE;
                end
                else
                begin
                    if (st)
                    begin
                        s.buck_duty = d;
                    end
                    else
                    begin
                        s.boost_duty = d;
                    end
                    accepted = 1'b1;
                    if (!self_en)
                    begin
                        status = ST_STAGED;
                    end
                    else if (cmd.operation == OP_MANUAL_SET && d <= cfg.min_enabled_duty)
                    begin
                        s      = stage_off(s, st);
                        status = ST_ZERO_DIS;
                    end
                    else
                    begin
                        s      = drive(s, st, d, cfg.complementary_mode);
                        status = ST_APPLIED;
                    end
                end
            end
            OP_ENABLE, OP_ENABLE_BOTH:
            begin
                if (!cfg.hardware_ready)
                begin
                    s.fault = 1'b1;
                    status  = ST_NOT_READY;
                end
                else if (cur.fault)
                begin
                    status = ST_FAULT_HELD;
                end
                else if (cmd.operation == OP_ENABLE_BOTH)
                begin
                    if (ok0 && ok1)
                    begin
                        s = drive(s, 1'b0, cur.boost_duty, cfg.complementary_mode);
                        s = drive(s, 1'b1, cur.buck_duty, cfg.complementary_mode);
                        s.boost_en = 1'b1;
                        s.buck_en  = 1'b1;
                        accepted   = 1'b1;
                        status     = ST_APPLIED;
                    end
                    else
                    begin
                        s      = stage_off(stage_off(s, 1'b0), 1'b1);
                        status = ST_ZERO_REFUSED;
                    end
                end
                else if (cmd.stage_select == SEL_ALL || cmd.stage_select == SEL_UNKNOWN)
                begin
                    s       = stage_off(stage_off(s, 1'b0), 1'b1);
                    s.fault = 1'b1;
                    status  = ST_STAGE;
                end
                else if (!cfg.allow_dual_stage && other_en)
                begin
                    s       = stage_off(stage_off(s, 1'b0), 1'b1);
                    s.fault = 1'b1;
                    status  = ST_INTERLOCK;
                end
                else if (oks)
                begin
                    s = drive(s, st, st ? cur.buck_duty : cur.boost_duty,
                              cfg.complementary_mode);
                    if (st)
                    begin
                        s.buck_en = 1'b1;
                    end
                    else
                    begin
                        s.boost_en = 1'b1;
                    end
                    accepted = 1'b1;
                    status   = ST_APPLIED;
                end
                else
                begin
                    s      = stage_off(s, st);
                    status = ST_ZERO_REFUSED;
                end
            end
            OP_DISABLE:
            begin
                if (cmd.stage_select == SEL_BOOST || cmd.stage_select == SEL_BUCK)
                begin
                    s        = stage_off(s, st);
                    accepted = 1'b1;
                    status   = ST_APPLIED;
                end
                else if (cmd.stage_select == SEL_ALL)
                begin
                    s        = stage_off(stage_off(s, 1'b0), 1'b1);
                    accepted = 1'b1;
                    status   = ST_APPLIED;
                end
                else
                begin
                    s       = stage_off(stage_off(s, 1'b0), 1'b1);
                    s.fault = 1'b1;
                    status  = ST_STAGE;
                end
            end
            default:
            begin
                status = ST_STAGE;
            end
        endcase
        nxt = s;
    end

endmodule

`default_nettype wire

// ----- rtl/buck_boost_pwm_supervisor.sv -----
// ----------------------------------------------------------------------------
// buck_boost_pwm_supervisor
// Safety supervisor for one boost and one buck PWM stage.
//
// Usage:
//   s_axis carries one command request: tuser holds operation and stage
//   select, tdata holds the signed duty request. m_axis returns one status
//   request per command with the enable flags, the fault latch and the four
//   operator compare values after the command.
//   The cfg channel writes one register per request (cfg_addr is the register
//   index); it is always ready. The user must write it only while the block is
//   idle; the block does not enforce this. The result is on m_axis in the cycle
//   after acceptance; throughput is one command per cycle while m_axis is ready,
//   set by the single output register. On a stall the result is held on m_axis
//   and s_axis takes one more command only once it is taken. Reset clears the
//   enable flags, fault latch, staged duties and compares, and loads the
//   register defaults. Only reset clears the fault latch.
// ----------------------------------------------------------------------------
`default_nettype none

module buck_boost_pwm_supervisor #(
    parameter int DUTY_FULL_SCALE = 100000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [17:0] duty_request, [23:18] zero
    input  logic [bbps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] operation, [4:3] stage_select
    input  logic [bbps_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] accepted, [4:1] status, [5] boost_on, [6] buck_on, [7] fault_flag,
    // [24:8] boost_compare_a, [41:25] boost_compare_b, [58:42] buck_compare_a,
    // [75:59] buck_compare_b, [79:76] zero
    output logic [bbps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbps_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [bbps_pkg::DUTY_W-1:0]         cfg_data
);
    import bbps_pkg::*;

    cfg_t       cfg_reg;
    sup_state_t state_reg;
    sup_state_t state_next;
    cmd_t       cmd;
    logic       accepted;
    status_t    status;
    logic       in_fire;
    logic       out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign cmd.operation    = s_axis_tuser[OP_W-1:0];
    assign cmd.stage_select = s_axis_tuser[OP_W+SEL_W-1:OP_W];
    assign cmd.duty_request = s_axis_tdata[REQ_W-1:0];

    bbps_core #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
    ) u_core (
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .cur      (state_reg),
        .nxt      (state_next),
        .accepted (accepted),
        .status   (status)
    );

    assign out_data_next = {4'd0,
                            state_next.buck_b,
                            state_next.buck_a,
                            state_next.boost_b,
                            state_next.boost_a,
                            state_next.fault,
                            state_next.buck_en,
                            state_next.boost_en,
                            status,
                            accepted};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hardware_ready     <= 1'b0;
            cfg_reg.complementary_mode <= 1'b0;
            cfg_reg.allow_dual_stage   <= 1'b0;
            cfg_reg.manual_max_duty    <= RST_MANUAL_MAX;
            cfg_reg.boost_control_max  <= RST_BOOST_CTRL;
            cfg_reg.buck_control_max   <= RST_BUCK_CTRL;
            cfg_reg.min_enabled_duty   <= RST_MIN_ENABLED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_HARDWARE_READY:     cfg_reg.hardware_ready     <= cfg_data[0];
                CFG_COMPLEMENTARY_MODE: cfg_reg.complementary_mode <= cfg_data[0];
                CFG_ALLOW_DUAL_STAGE:   cfg_reg.allow_dual_stage   <= cfg_data[0];
                CFG_MANUAL_MAX_DUTY:    cfg_reg.manual_max_duty    <= cfg_data;
                CFG_BOOST_CONTROL_MAX:  cfg_reg.boost_control_max  <= cfg_data;
                CFG_BUCK_CONTROL_MAX:   cfg_reg.buck_control_max   <= cfg_data;
                CFG_MIN_ENABLED_DUTY:   cfg_reg.min_enabled_duty   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- bench/buck_boost_pwm_supervisor_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buck_boost_pwm_supervisor_test
// Self-checking bench for the boost/buck PWM supervisor.
//
// Commands go in on s_axis and every status request on m_axis is checked field
// by field against a behavioral copy of the supervisor that runs alongside.
// A directed pass covers limits, staging, zero handling, enable-both and the
// complementary drive. Random passes with clean command sequences follow,
// each with its own register set and its own idle and stall pattern. Fault
// handling comes last, since only reset clears the fault latch.
// ----------------------------------------------------------------------------
module buck_boost_pwm_supervisor_test;
    import bbps_pkg::*;

    localparam int FULL_SCALE  = 100000;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [OP_W-1:0] OP_UNUSED_LOW  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HIGH = 3'd7;

    // m_axis_tdata layout, highest field first
    typedef struct packed {
        logic [3:0]        pad;
        logic [DUTY_W-1:0] buck_b;
        logic [DUTY_W-1:0] buck_a;
        logic [DUTY_W-1:0] boost_b;
        logic [DUTY_W-1:0] boost_a;
        logic              fault;
        logic              buck_on;
        logic              boost_on;
        status_t           status;
        logic              accepted;
    } supervisor_report_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_AW-1:0]      cfg_addr      = '0;
    logic [DUTY_W-1:0]      cfg_data      = '0;

    cfg_t              regs;
    logic [DUTY_W-1:0] staged_duty [2];
    logic              stage_on [2];
    logic              fault_latched;
    logic [DUTY_W-1:0] compare [4];

    supervisor_report_t expected_results [$];
    int unsigned        error_count   = 0;
    int unsigned        cycle_count   = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;

    buck_boost_pwm_supervisor #(
        .DUTY_FULL_SCALE(FULL_SCALE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void reset_supervisor_state();
        regs                    = '0;
        regs.manual_max_duty    = RST_MANUAL_MAX;
        regs.boost_control_max  = RST_BOOST_CTRL;
        regs.buck_control_max   = RST_BUCK_CTRL;
        regs.min_enabled_duty   = RST_MIN_ENABLED;
        fault_latched           = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            staged_duty[i] = '0;
            stage_on[i]    = 1'b0;
        end
        for (int i = 0; i < 4; i++)
            compare[i] = '0;
    endfunction

    function automatic void stage_off(int st);
        compare[2 * st]     = '0;
        compare[2 * st + 1] = '0;
        stage_on[st]        = 1'b0;
    endfunction

    function automatic void all_stages_off();
        stage_off(0);
        stage_off(1);
    endfunction

    function automatic void drive_stage(int st, logic [DUTY_W-1:0] duty);
        if (st == 0)
        begin
            if (regs.complementary_mode)
                compare[0] = (duty > FULL_SCALE) ? '0 : DUTY_W'(FULL_SCALE - int'(duty));
            else
            begin
                compare[0] = '0;
                compare[1] = duty;
            end
        end
        else
        begin
            compare[2] = duty;
            if (!regs.complementary_mode)
                compare[3] = '0;
        end
    endfunction

    function automatic logic try_enable(int st);
        if (staged_duty[st] <= regs.min_enabled_duty)
        begin
            stage_off(st);
            return 1'b0;
        end
        drive_stage(st, staged_duty[st]);
        return 1'b1;
    endfunction

    function automatic supervisor_report_t supervise(logic [OP_W-1:0] op,
                                                     logic [SEL_W-1:0] sel,
                                                     logic signed [REQ_W-1:0] req);
        supervisor_report_t r;
        logic [DUTY_W-1:0]  limit;
        logic [DUTY_W-1:0]  d;
        logic               ok;
        logic               b0;
        logic               b1;
        int                 st;
        status_t            status;

        r      = '0;
        ok     = 1'b0;
        status = ST_STAGE;
        st     = int'(sel[0]);
        d      = req[DUTY_W-1:0];
        case (op)
            OP_MANUAL_SET, OP_CONTROL_SET:
            begin
                limit = regs.manual_max_duty;
                if (op == OP_CONTROL_SET)
                    limit = (sel == SEL_BUCK) ? regs.buck_control_max : regs.boost_control_max;
                if (!regs.hardware_ready)
                begin
                    fault_latched = 1'b1;
                    status        = ST_NOT_READY;
                end
                else if (req < 0 || d > limit)
                begin
                    fault_latched = 1'b1;
                    all_stages_off();
                    status = ST_RANGE;
                end
                else if (sel > SEL_BUCK)
                begin
                    fault_latched = 1'b1;
                    all_stages_off();
                    status = ST_STAGE;
                end
                else
                begin
                    staged_duty[st] = d;
                    ok              = 1'b1;
                    if (!stage_on[st])
                        status = ST_STAGED;
                    else if (op == OP_MANUAL_SET && d <= regs.min_enabled_duty)
                    begin
                        stage_off(st);
                        status = ST_ZERO_DIS;
                    end
                    else
                    begin
                        drive_stage(st, d);
                        status = ST_APPLIED;
                    end
                end
            end
            OP_ENABLE, OP_ENABLE_BOTH:
            begin
                if (!regs.hardware_ready)
                begin
                    fault_latched = 1'b1;
                    status        = ST_NOT_READY;
                end
                else if (fault_latched)
                    status = ST_FAULT_HELD;
                else if (op == OP_ENABLE_BOTH)
                begin
                    b0          = try_enable(0);
                    b1          = try_enable(1);
                    stage_on[0] = b0;
                    stage_on[1] = b1;
                    if (b0 && b1)
                    begin
                        ok     = 1'b1;
                        status = ST_APPLIED;
                    end
                    else
                    begin
                        all_stages_off();
                        status = ST_ZERO_REFUSED;
                    end
                end
                else if (sel > SEL_BUCK)
                begin
                    fault_latched = 1'b1;
                    all_stages_off();
                    status = ST_STAGE;
                end
                else if (!regs.allow_dual_stage && stage_on[1 - st])
                begin
                    fault_latched = 1'b1;
                    all_stages_off();
                    status = ST_INTERLOCK;
                end
                else
                begin
                    b0           = try_enable(st);
                    stage_on[st] = b0;
                    ok           = b0;
                    status       = b0 ? ST_APPLIED : ST_ZERO_REFUSED;
                end
            end
            OP_DISABLE:
            begin
                if (sel == SEL_ALL)
                begin
                    all_stages_off();
                    ok     = 1'b1;
                    status = ST_APPLIED;
                end
                else if (sel == SEL_UNKNOWN)
                begin
                    all_stages_off();
                    fault_latched = 1'b1;
                    status        = ST_STAGE;
                end
                else
                begin
                    stage_off(st);
                    ok     = 1'b1;
                    status = ST_APPLIED;
                end
            end
            default:
                status = ST_STAGE;
        endcase

        r.accepted = ok;
        r.status   = status;
        r.boost_on = stage_on[0];
        r.buck_on  = stage_on[1];
        r.fault    = fault_latched;
        r.boost_a  = compare[0];
        r.boost_b  = compare[1];
        r.buck_a   = compare[2];
        r.buck_b   = compare[3];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    task automatic send_command(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel, int duty);
        logic [REQ_W-1:0] req_bits;

        req_bits = duty[REQ_W-1:0];
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - REQ_W){1'b0}}, req_bits};
        s_axis_tuser  <= {sel, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(supervise(op, sel, req_bits));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_AW-1:0] addr, logic [DUTY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (addr)
            CFG_HARDWARE_READY:     regs.hardware_ready     = value[0];
            CFG_COMPLEMENTARY_MODE: regs.complementary_mode = value[0];
            CFG_ALLOW_DUAL_STAGE:   regs.allow_dual_stage   = value[0];
            CFG_MANUAL_MAX_DUTY:    regs.manual_max_duty    = value;
            CFG_BOOST_CONTROL_MAX:  regs.boost_control_max  = value;
            CFG_BUCK_CONTROL_MAX:   regs.buck_control_max   = value;
            CFG_MIN_ENABLED_DUTY:   regs.min_enabled_duty   = value;
            default:                regs                    = regs;
        endcase
    endtask

    task automatic load_registers(cfg_t next);
        drain_results();
        write_register(CFG_HARDWARE_READY, DUTY_W'(next.hardware_ready));
        write_register(CFG_COMPLEMENTARY_MODE, DUTY_W'(next.complementary_mode));
        write_register(CFG_ALLOW_DUAL_STAGE, DUTY_W'(next.allow_dual_stage));
        write_register(CFG_MANUAL_MAX_DUTY, next.manual_max_duty);
        write_register(CFG_BOOST_CONTROL_MAX, next.boost_control_max);
        write_register(CFG_BUCK_CONTROL_MAX, next.buck_control_max);
        write_register(CFG_MIN_ENABLED_DUTY, next.min_enabled_duty);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_duty(logic [DUTY_W-1:0] limit);
        int floor_duty;

        floor_duty = int'(regs.min_enabled_duty);
        case ($urandom_range(5))
            0:       return 0;
            1:       return int'(limit);
            2:       return (floor_duty <= limit) ? floor_duty : int'(limit);
            3:       return (floor_duty + 1 <= limit) ? floor_duty + 1 : int'(limit);
            default: return int'($urandom_range(int'(limit)));
        endcase
    endfunction

    function automatic int noise_duty();
        case ($urandom_range(7))
            0:       return -FULL_SCALE;
            1:       return FULL_SCALE;
            2:       return -1;
            3:       return int'($urandom_range(int'(regs.manual_max_duty)));
            default: return int'($urandom_range(2 * FULL_SCALE)) - FULL_SCALE;
        endcase
    endfunction

    task automatic send_clean_command();
        int                unsigned pick;
        logic [OP_W-1:0]   op;
        logic [SEL_W-1:0]  sel;
        logic [DUTY_W-1:0] limit;
        int                duty;

        pick = $urandom_range(99);
        sel  = SEL_W'($urandom_range(1));
        duty = noise_duty();
        if (pick < 45)
        begin
            op = ($urandom_range(1) == 0) ? OP_MANUAL_SET : OP_CONTROL_SET;
            if (op == OP_MANUAL_SET)
                limit = regs.manual_max_duty;
            else
                limit = (sel == SEL_BUCK) ? regs.buck_control_max : regs.boost_control_max;
            duty = pick_duty(limit);
        end
        else if (pick < 68)
        begin
            op = OP_ENABLE;
            // drop the other stage instead of tripping the interlock
            if (!regs.allow_dual_stage && stage_on[1 - int'(sel[0])])
            begin
                op  = OP_DISABLE;
                sel = (sel == SEL_BOOST) ? SEL_BUCK : SEL_BOOST;
            end
        end
        else if (pick < 80)
        begin
            op  = OP_ENABLE_BOTH;
            sel = SEL_W'($urandom_range(3));
        end
        else
        begin
            op  = OP_DISABLE;
            sel = SEL_W'($urandom_range(2));
        end
        if ($urandom_range(59) == 0)
            drain_results();
        send_command(op, sel, duty);
    endtask

    task automatic test_directed_operation();
        cfg_t next;

        next                = regs;
        next.hardware_ready = 1'b1;
        load_registers(next);
        send_command(OP_MANUAL_SET, SEL_BOOST, 0);
        send_command(OP_MANUAL_SET, SEL_BOOST, 30000);
        send_command(OP_ENABLE, SEL_BOOST, 0);
        send_command(OP_MANUAL_SET, SEL_BOOST, 1);
        send_command(OP_ENABLE, SEL_BOOST, 0);
        send_command(OP_CONTROL_SET, SEL_BUCK, 85000);
        send_command(OP_ENABLE, SEL_BUCK, -FULL_SCALE);
        send_command(OP_CONTROL_SET, SEL_BUCK, 0);
        send_command(OP_ENABLE_BOTH, SEL_UNKNOWN, FULL_SCALE);
        send_command(OP_MANUAL_SET, SEL_BOOST, 2);
        send_command(OP_MANUAL_SET, SEL_BUCK, 30000);
        send_command(OP_ENABLE_BOTH, SEL_ALL, 0);
        send_command(OP_DISABLE, SEL_ALL, 0);

        next.complementary_mode = 1'b1;
        next.allow_dual_stage   = 1'b1;
        next.manual_max_duty    = DUTY_W'(FULL_SCALE);
        next.boost_control_max  = DUTY_W'(FULL_SCALE);
        next.buck_control_max   = DUTY_W'(FULL_SCALE);
        next.min_enabled_duty   = '0;
        load_registers(next);
        send_command(OP_CONTROL_SET, SEL_BOOST, FULL_SCALE);
        send_command(OP_ENABLE, SEL_BOOST, 0);
        send_command(OP_MANUAL_SET, SEL_BUCK, FULL_SCALE);
        send_command(OP_ENABLE, SEL_BUCK, 0);
        send_command(OP_MANUAL_SET, SEL_BOOST, 0);
        send_command(OP_DISABLE, SEL_BUCK, 0);
    endtask

    task automatic run_clean_phase(cfg_t next, int unsigned idle, int unsigned stall,
                                   int count);
        load_registers(next);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count) send_clean_command();
    endtask

    task automatic test_random_operation();
        cfg_t next;

        next = regs;
        next.complementary_mode = 1'b0;
        next.allow_dual_stage   = 1'b0;
        next.manual_max_duty    = RST_MANUAL_MAX;
        next.boost_control_max  = RST_BOOST_CTRL;
        next.buck_control_max   = RST_BUCK_CTRL;
        next.min_enabled_duty   = RST_MIN_ENABLED;
        run_clean_phase(next, 0, 0, 150);

        next.complementary_mode = 1'b1;
        next.allow_dual_stage   = 1'b1;
        next.manual_max_duty    = DUTY_W'(FULL_SCALE);
        next.boost_control_max  = DUTY_W'(FULL_SCALE);
        next.buck_control_max   = DUTY_W'(FULL_SCALE);
        next.min_enabled_duty   = '0;
        run_clean_phase(next, 54, 0, 150);

        next.complementary_mode = 1'b0;
        next.manual_max_duty    = '0;
        next.buck_control_max   = '0;
        next.min_enabled_duty   = DUTY_W'(FULL_SCALE);
        run_clean_phase(next, 0, 54, 100);

        next.complementary_mode = 1'b1;
        next.allow_dual_stage   = 1'b0;
        next.manual_max_duty    = DUTY_W'($urandom_range(FULL_SCALE));
        next.boost_control_max  = DUTY_W'($urandom_range(FULL_SCALE));
        next.buck_control_max   = DUTY_W'($urandom_range(FULL_SCALE));
        next.min_enabled_duty   = DUTY_W'($urandom_range(2000));
        run_clean_phase(next, 25, 25, 150);
    endtask

    task automatic test_fault_handling();
        cfg_t next;

        next                    = regs;
        next.complementary_mode = 1'b0;
        next.allow_dual_stage   = 1'b0;
        next.manual_max_duty    = RST_MANUAL_MAX;
        next.boost_control_max  = RST_BOOST_CTRL;
        next.buck_control_max   = RST_BUCK_CTRL;
        next.min_enabled_duty   = RST_MIN_ENABLED;
        load_registers(next);
        send_idle_pct = 0;
        stall_pct     = 0;
        send_command(OP_MANUAL_SET, SEL_BOOST, 20000);
        send_command(OP_MANUAL_SET, SEL_BUCK, 20000);
        send_command(OP_ENABLE, SEL_BOOST, 0);
        // only one command can trip the clear latch
        if ($urandom_range(1) == 0)
            send_command(OP_ENABLE, SEL_BUCK, 0);
        else
            send_command(OP_ENABLE, SEL_W'($urandom_range(3, 2)), 0);
        send_command(OP_ENABLE, SEL_BOOST, 0);
        send_command(OP_MANUAL_SET, SEL_BOOST, -1);
        send_command(OP_CONTROL_SET, SEL_BUCK, 85001);
        send_command(OP_MANUAL_SET, SEL_ALL, 100);
        send_command(OP_MANUAL_SET, SEL_BUCK, 100);
        send_command(OP_DISABLE, SEL_UNKNOWN, 0);
        send_command(OP_DISABLE, SEL_ALL, 0);
        send_command(OP_UNUSED_LOW, SEL_BOOST, 0);
        send_command(OP_UNUSED_HIGH, SEL_UNKNOWN, -FULL_SCALE);

        next.hardware_ready = 1'b0;
        load_registers(next);
        send_command(OP_ENABLE_BOTH, SEL_BOOST, 0);
        send_command(OP_CONTROL_SET, SEL_BOOST, 0);

        send_idle_pct = 25;
        stall_pct     = 25;
        repeat (50) send_command(OP_W'($urandom_range(4)), SEL_W'($urandom_range(3)),
                                 noise_duty());

        next.hardware_ready     = 1'b1;
        next.complementary_mode = 1'($urandom_range(1));
        next.allow_dual_stage   = 1'($urandom_range(1));
        next.manual_max_duty    = DUTY_W'($urandom_range(FULL_SCALE));
        next.boost_control_max  = DUTY_W'($urandom_range(FULL_SCALE));
        next.buck_control_max   = DUTY_W'($urandom_range(FULL_SCALE));
        next.min_enabled_duty   = DUTY_W'($urandom_range(FULL_SCALE));
        load_registers(next);
        repeat (150) send_command(OP_W'($urandom_range(4)), SEL_W'($urandom_range(3)),
                                  noise_duty());
    endtask

    always @(posedge clk)
    begin
        supervisor_report_t got;
        supervisor_report_t want;

        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_results.size() == 0)
                report_mismatch("unrequested result, pending count", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", got.accepted, want.accepted);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.boost_on !== want.boost_on)
                    report_mismatch("boost_on", got.boost_on, want.boost_on);
                if (got.buck_on !== want.buck_on)
                    report_mismatch("buck_on", got.buck_on, want.buck_on);
                if (got.fault !== want.fault)
                    report_mismatch("fault_flag", got.fault, want.fault);
                if (got.boost_a !== want.boost_a)
                    report_mismatch("boost_compare_a", got.boost_a, want.boost_a);
                if (got.boost_b !== want.boost_b)
                    report_mismatch("boost_compare_b", got.boost_b, want.boost_b);
                if (got.buck_a !== want.buck_a)
                    report_mismatch("buck_compare_a", got.buck_a, want.buck_a);
                if (got.buck_b !== want.buck_b)
                    report_mismatch("buck_compare_b", got.buck_b, want.buck_b);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        reset_supervisor_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_operation();
        test_random_operation();
        test_fault_handling();
        drain_results();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
